@@ rtl/stks_pkg.sv @@
package stks_pkg;

  // Default depth of the insertion chain and reset value of the keep count.
  localparam int unsigned MaxKeepDef   = 16;
  localparam logic [4:0]  KeepCountRst = 5'd10;

  // One stored word: a document and its signed Q16.16 score.
  typedef struct packed {
    logic [31:0]        id;
    logic signed [31:0] score;
  } entry_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_cmd_e;

  // Control of the top level: collecting candidates or draining the chain.
  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_e;

endpackage

@@ rtl/stks_cell.sv @@
module stks_cell (
  input  logic               clk_i,
  input  stks_pkg::cell_cmd_e cmd_i,
  input  logic               occupied_i,
  input  stks_pkg::entry_t   cand_i,
  input  stks_pkg::entry_t   prev_i,
  input  stks_pkg::entry_t   next_i,
  output stks_pkg::entry_t   entry_o,
  output logic               beats_o
);
  import stks_pkg::*;

  entry_t entry_q, entry_d;

  // A candidate belongs above this cell when the cell is empty or holds a strictly
  // lower score; equal scores keep the earlier arrival in front.
  assign beats_o = !occupied_i || ($signed(cand_i.score) > $signed(entry_q.score));

  // Select the word to hold next: keep, take the candidate, or shift along the chain.
  always_comb begin
    case (cmd_i)
      CELL_HOLD:      entry_d = entry_q;
      CELL_LOAD_NEW:  entry_d = cand_i;
      CELL_FROM_PREV: entry_d = prev_i;
      CELL_FROM_NEXT: entry_d = next_i;
      default:        entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/streaming_top_k_select.sv @@
// Channel   Direction  Handshake               Word
// input     in         start / busy            doc_id_i, doc_score_i, end_of_set_i
// result    out        out_valid_o (strobe)    out_doc_id_o, out_score_o, out_rank_o,
//                                              out_last_o
// config    in         cfg_valid_i/cfg_ready_o cfg_keep_count_i
//
// A candidate without end_of_set is inserted into the sorted cell chain at the
// edge that accepts it, and busy stays low.
// A candidate with end_of_set is inserted the same way, then the chain drains one
// kept entry per cycle from its head, n = min(held, k) entries, while busy is high.
// Reset clears the held count, the state and the keep count (to ten); the cells
// themselves are not cleared. The receiver cannot stall the result strobe.
module streaming_top_k_select #(
  parameter int unsigned MaxKeep = stks_pkg::MaxKeepDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        doc_id_i,
  input  logic signed [31:0] doc_score_i,
  input  logic               end_of_set_i,
  output logic               out_valid_o,
  output logic [31:0]        out_doc_id_o,
  output logic signed [31:0] out_score_o,
  output logic [3:0]         out_rank_o,
  output logic               out_last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_keep_count_i
);
  import stks_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxKeep + 1);
  localparam int unsigned RankW = (CntW > 4) ? CntW : 4;

  state_e          state_q, state_d;
  logic [4:0]      keep_q;
  logic [CntW-1:0] held_q, held_d;
  logic [CntW-1:0] num_q, num_d;
  logic [CntW-1:0] rank_q, rank_d;
  logic [CntW-1:0] eff_k;
  logic [CntW-1:0] held_after;
  logic [RankW-1:0] rank_ext;
  logic            accept;
  logic            admit;
  logic            grow;
  logic            emit_done;
  entry_t          cand;
  entry_t          chain [MaxKeep];
  cell_cmd_e       cmd [MaxKeep];
  logic [MaxKeep-1:0] beats;
  logic [MaxKeep-1:0] occ;

  assign cand.id    = doc_id_i;
  assign cand.score = doc_score_i;
  assign accept     = start && !busy;

  // Effective keep count: zero reads as one, values above the chain length saturate.
  always_comb begin
    if (keep_q == 5'd0) begin
      eff_k = CntW'(1);
    end else if (int'(keep_q) > int'(MaxKeep)) begin
      eff_k = CntW'(MaxKeep);
    end else begin
      eff_k = CntW'(keep_q);
    end
  end

  // Cells below the held count carry live entries.
  always_comb begin
    for (int i = 0; i < MaxKeep; i++) begin
      occ[i] = CntW'(i) < held_q;
    end
  end

  // Admit while not full, or when the candidate beats some live entry (hence the minimum).
  assign grow       = held_q < eff_k;
  assign admit      = grow || |(beats & occ);
  assign held_after = (admit && grow) ? held_q + CntW'(1) : held_q;

  // Per-cell load commands: insertion point, shift below it, or drain towards the head.
  always_comb begin
    for (int i = 0; i < MaxKeep; i++) begin
      cmd[i] = CELL_HOLD;
      if (state_q == ST_EMIT) begin
        cmd[i] = CELL_FROM_NEXT;
      end else if (accept && admit) begin
        if (i > 0 && beats[(i > 0) ? i - 1 : 0]) begin
          cmd[i] = CELL_FROM_PREV;
        end else if (beats[i]) begin
          cmd[i] = CELL_LOAD_NEW;
        end
      end
    end
  end

  // The chain of cells.
  for (genvar g = 0; g < MaxKeep; g++) begin : g_cell
    entry_t prev_w, next_w;
    if (g == 0) begin : g_head
      assign prev_w = cand;
    end else begin : g_mid
      assign prev_w = chain[g-1];
    end
    if (g == MaxKeep - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_body
      assign next_w = chain[g+1];
    end
    stks_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd[g]),
      .occupied_i (occ[g]),
      .cand_i     (cand),
      .prev_i     (prev_w),
      .next_i     (next_w),
      .entry_o    (chain[g]),
      .beats_o    (beats[g])
    );
  end

  assign emit_done = (rank_q == num_q - CntW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: if (accept && end_of_set_i) state_d = ST_EMIT;
      ST_EMIT:    if (emit_done) state_d = ST_COLLECT;
      default:    state_d = ST_COLLECT;
    endcase
  end

  // Counters and outputs.
  always_comb begin
    held_d      = held_q;
    num_d       = num_q;
    rank_d      = rank_q;
    busy        = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_COLLECT: begin
        if (accept) begin
          held_d = held_after;
          num_d  = (held_after < eff_k) ? held_after : eff_k;
          rank_d = '0;
        end
      end
      ST_EMIT: begin
        busy        = 1'b1;
        out_valid_o = 1'b1;
        rank_d      = rank_q + CntW'(1);
        if (emit_done) held_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      held_q  <= '0;
      num_q   <= '0;
      rank_q  <= '0;
      keep_q  <= KeepCountRst;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      num_q   <= num_d;
      rank_q  <= rank_d;
      if (cfg_valid_i && cfg_ready_o) keep_q <= cfg_keep_count_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // The head cell carries the word being emitted.
  assign rank_ext     = RankW'(rank_q);
  assign out_doc_id_o = chain[0].id;
  assign out_score_o  = chain[0].score;
  assign out_rank_o   = rank_ext[3:0];
  assign out_last_o   = emit_done;

endmodule
